FILE: design/lru_key_value_cache_top_defines.svh
// Assertion macros shared by the LRU key-value cache design files.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");
`else
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/lkv_pkg.sv
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic evict;
        logic fill;
    } lkv_flags_t;

endpackage

FILE: design/lkv_lookup.sv
// Parallel key match, victim and free-slot selection for one operation.
module lkv_lookup
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                  kind,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [CAP_BITS-1:0]   capacity,
    input  logic [ENTRIES-1:0]    entry_valid,
    input  logic [KEY_BITS-1:0]   entry_key [ENTRIES],
    input  logic [VALUE_BITS-1:0] entry_value [ENTRIES],
    input  logic [IDX_W-1:0]      entry_rank [ENTRIES],
    input  logic [CNT_W-1:0]      used_count,
    output lkv_flags_t            flags,
    output logic [IDX_W-1:0]      slot,
    output logic [CNT_W-1:0]      old_rank,
    output logic [VALUE_BITS-1:0] hit_value
);

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] lru_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   lru_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [CNT_W-1:0]   eff_cap;
    logic [IDX_W-1:0]   lru_rank;
    logic               is_put;
    logic               any_hit;
    logic               need_evict;

    assign is_put   = (kind == KIND_PUT);
    assign lru_rank = IDX_W'(used_count - CNT_W'(1));

    always_comb
    begin
        if (capacity == '0)
            eff_cap = CNT_W'(1);
        else if (int'(capacity) > ENTRIES)
            eff_cap = CNT_W'(ENTRIES);
        else
            eff_cap = CNT_W'(capacity);
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = entry_valid[i] && (entry_key[i] == key);
            lru_vec[i] = entry_valid[i] && (entry_rank[i] == lru_rank);
        end
    end

    // Scanning downward leaves the lowest-numbered match in each index.
    always_comb
    begin
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = IDX_W'(i);
            if (lru_vec[i])
                lru_idx = IDX_W'(i);
            if (!entry_valid[i])
                free_idx = IDX_W'(i);
        end
    end

    assign any_hit    = |hit_vec;
    assign need_evict = (used_count >= eff_cap);

    always_comb
    begin
        flags.is_put = is_put;
        flags.hit    = any_hit;
        flags.evict  = is_put && !any_hit && need_evict && (|lru_vec);
        flags.fill   = is_put && !any_hit && !need_evict && !(&entry_valid);
    end

    always_comb
    begin
        if (any_hit)
        begin
            slot     = hit_idx;
            old_rank = CNT_W'(entry_rank[hit_idx]);
        end
        else if (need_evict)
        begin
            slot     = lru_idx;
            old_rank = used_count - CNT_W'(1);
        end
        else
        begin
            slot     = free_idx;
            old_rank = used_count;
        end
    end

    assign hit_value = entry_value[hit_idx];

endmodule

FILE: design/lkv_store.sv
// Entry storage: valid bits, keys, values, recency ranks and fill count.
`include "lru_key_value_cache_top_defines.svh"
module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd_en,
    input  lkv_flags_t            flags,
    input  logic [IDX_W-1:0]      slot,
    input  logic [CNT_W-1:0]      old_rank,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    output logic [ENTRIES-1:0]    entry_valid,
    output logic [KEY_BITS-1:0]   entry_key [ENTRIES],
    output logic [VALUE_BITS-1:0] entry_value [ENTRIES],
    output logic [IDX_W-1:0]      entry_rank [ENTRIES],
    output logic [CNT_W-1:0]      used_count
);

    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_BITS-1:0]   key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [IDX_W-1:0]      rank_reg [ENTRIES];
    logic [CNT_W-1:0]      used_count_reg;
    logic                  touch;
    logic                  write_key;
    logic                  write_value;

    assign touch       = upd_en && (flags.hit || flags.evict || flags.fill);
    assign write_key   = upd_en && (flags.evict || flags.fill);
    assign write_value = touch && flags.is_put;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            used_count_reg <= '0;
        end
        else if (upd_en && flags.fill)
        begin
            valid_reg[slot] <= 1'b1;
            used_count_reg  <= used_count_reg + CNT_W'(1);
        end
    end

    // Touching an entry makes it rank zero; every entry more recent than it ages by one.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (touch)
            begin
                if (slot == IDX_W'(i))
                    rank_reg[i] <= '0;
                else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < old_rank))
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
            end
            if (write_key && (slot == IDX_W'(i)))
                key_reg[i] <= new_key;
            if (write_value && (slot == IDX_W'(i)))
                value_reg[i] <= new_value;
        end
    end

    assign entry_valid = valid_reg;
    assign entry_key   = key_reg;
    assign entry_value = value_reg;
    assign entry_rank  = rank_reg;
    assign used_count  = used_count_reg;

    `LKV_ASSERT_NOW(a_count_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_reg) == int'(used_count_reg))
    `LKV_ASSERT_NOW(a_fill_free_slot, clk, rst_n, upd_en && flags.fill, !valid_reg[slot])
    `LKV_ASSERT_NEXT(a_evict_keeps_count, clk, rst_n, upd_en && flags.evict,
        $stable(used_count_reg))

endmodule

FILE: design/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// An accepted beat is registered at the accepting edge, looked up and applied to the
// entries in the following cycle, and its result shows on done in the cycle after that.
// One get or put per cycle; busy stays low, since the whole match and rank update of an
// item takes place between the input register and the result register.
// Reset empties the cache and sets the capacity register to 16.
`include "lru_key_value_cache_top_defines.svh"
module lru_key_value_cache_top
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic signed [KEY_BITS-1:0]   lookup_key,
    input  logic signed [VALUE_BITS-1:0] write_value,
    output logic                         done,
    output logic                         hit,
    output logic signed [VALUE_BITS-1:0] read_value,
    output logic                         evicted,
    input  logic                         cfg_we,
    input  logic [CAP_BITS-1:0]          cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [CAP_BITS-1:0]   cap_reg;

    logic                  done_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic [VALUE_BITS-1:0] read_value_next;
    logic                  evicted_reg;

    logic [ENTRIES-1:0]    entry_valid;
    logic [KEY_BITS-1:0]   entry_key [ENTRIES];
    logic [VALUE_BITS-1:0] entry_value [ENTRIES];
    logic [IDX_W-1:0]      entry_rank [ENTRIES];
    logic [CNT_W-1:0]      used_count;
    lkv_flags_t            flags;
    logic [IDX_W-1:0]      slot;
    logic [CNT_W-1:0]      old_rank;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            cap_reg      <= CAP_RESET;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
        if (in_valid_reg)
        begin
            hit_reg        <= flags.hit;
            read_value_reg <= read_value_next;
            evicted_reg    <= flags.evict;
        end
    end

    lkv_lookup #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_lookup (
        .kind        (kind_reg),
        .key         (key_reg),
        .capacity    (cap_reg),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_rank  (entry_rank),
        .used_count  (used_count),
        .flags       (flags),
        .slot        (slot),
        .old_rank    (old_rank),
        .hit_value   (hit_value)
    );

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (in_valid_reg),
        .flags       (flags),
        .slot        (slot),
        .old_rank    (old_rank),
        .new_key     (key_reg),
        .new_value   (wval_reg),
        .entry_valid (entry_valid),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_rank  (entry_rank),
        .used_count  (used_count)
    );

    // Only a get that hits returns data; everything else reads back all ones.
    assign read_value_next = (flags.hit && !flags.is_put) ? hit_value : {VALUE_BITS{1'b1}};

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

    `LKV_ASSERT_NEXT(a_beat_gives_result, clk, rst_n, accept, ##1 done)
    `LKV_ASSERT_NOW(a_evict_is_miss, clk, rst_n, done && evicted,
        !hit && (read_value_reg == {VALUE_BITS{1'b1}}))
    `LKV_ASSERT_NOW(a_one_update_kind, clk, rst_n, in_valid_reg,
        $onehot0({flags.hit, flags.evict, flags.fill}))

endmodule
